FILE: hdl/etp_pkg.sv
// Package for the encoder period tachometer.
// Holds field widths, the speed numerator, opcodes and register indexes.
// No dependencies.
package etp_pkg;

    localparam int TIME_W    = 32;
    localparam int PPR_W     = 16;
    localparam int CFG_W     = 32;
    localparam int MAG_W     = 34;
    localparam int SPEED_W   = MAG_W + 1;
    localparam int DEN_W     = TIME_W + PPR_W;
    localparam int CNT_W     = $clog2(MAG_W);
    // pulse count digit folded into the denominator per multiply cycle
    localparam int DIG_W     = 4;
    localparam int MUL_STEPS = PPR_W / DIG_W;
    localparam int TERM_W    = TIME_W + DIG_W;

    // 60e6 us per minute, scaled by 2^8 fraction bits
    localparam logic [MAG_W-1:0]  SPEED_NUM        = 34'd15360000000;
    localparam logic [PPR_W-1:0]  PPR_RST          = 16'd1;
    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd100000;

    typedef enum logic [1:0] {
        OP_PULSE   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    localparam logic CFG_PPR  = 1'b0;
    localparam logic CFG_IDLE = 1'b1;

endpackage

FILE: hdl/etp_div.sv
// Digit-serial speed divider: period times pulse count four bits per cycle,
// then a restoring divide that retires one quotient bit per cycle.
// Depends on etp_pkg.
module etp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [etp_pkg::TIME_W-1:0]   i_period,
    input  logic [etp_pkg::PPR_W-1:0]    i_ppr,
    output logic                         o_done,
    output logic [etp_pkg::MAG_W-1:0]    o_quot
);

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN} t_dstate;

    t_dstate                       r_state, n_state;
    logic [etp_pkg::TIME_W-1:0]    r_period;
    logic [etp_pkg::PPR_W-1:0]     r_ppr, n_ppr;
    logic [etp_pkg::DEN_W-1:0]     r_den, n_den;
    logic [etp_pkg::MAG_W-1:0]     r_num, n_num;
    logic [etp_pkg::MAG_W-1:0]     r_rem, n_rem;
    logic [etp_pkg::MAG_W-1:0]     r_quot, n_quot;
    logic [etp_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_done, n_done;
    logic [etp_pkg::MAG_W-1:0]     partial;
    logic                          fits;
    logic [etp_pkg::TERM_W-1:0]    mul_term;

    // period times the top pulse-count digit
    assign mul_term = etp_pkg::TERM_W'(r_period)
                    * etp_pkg::TERM_W'(r_ppr[etp_pkg::PPR_W-1 -: etp_pkg::DIG_W]);

    // next partial remainder: bring down one dividend bit
    assign partial = {r_rem[etp_pkg::MAG_W-2:0], r_num[etp_pkg::MAG_W-1]};
    assign fits    = {{(etp_pkg::DEN_W-etp_pkg::MAG_W){1'b0}}, partial} >= r_den;

    always_comb begin
        n_state = r_state;
        n_ppr   = r_ppr;
        n_den   = r_den;
        n_num   = r_num;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_ppr   = i_ppr;
                    n_den   = '0;
                    n_cnt   = etp_pkg::CNT_W'(etp_pkg::MUL_STEPS - 1);
                    n_state = D_MUL;
                end
            end
            D_MUL: begin
                // fold in the next digit, most significant first
                n_den = {r_den[etp_pkg::DEN_W-etp_pkg::DIG_W-1:0], {etp_pkg::DIG_W{1'b0}}}
                      + etp_pkg::DEN_W'(mul_term);
                n_ppr = {r_ppr[etp_pkg::PPR_W-etp_pkg::DIG_W-1:0], {etp_pkg::DIG_W{1'b0}}};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_num   = etp_pkg::SPEED_NUM;
                    n_rem   = '0;
                    n_cnt   = etp_pkg::CNT_W'(etp_pkg::MAG_W - 1);
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_num  = {r_num[etp_pkg::MAG_W-2:0], 1'b0};
                n_rem  = fits ? (partial - r_den[etp_pkg::MAG_W-1:0]) : partial;
                n_quot = {r_quot[etp_pkg::MAG_W-2:0], fits};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        if (i_start && r_state == D_IDLE) begin
            r_period <= i_period;
        end
        r_ppr  <= n_ppr;
        r_den  <= n_den;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/encoder_period_tachometer.sv
// Top level of the encoder period tachometer.
// Depends on etp_pkg and etp_div.
//
// Period-based encoder tachometer. Each input item carries an opcode and a
// microsecond timestamp. A pulse item stores the interval since the previous
// pulse, the new timestamp and the direction (channel B high = forward); a
// restart item stores the timestamp, clears the interval and sets forward. A
// query item returns signed rpm * 256 = 15360000000 / (period * pulses per rev),
// truncated, or zero with stopped set when the interval is zero or more than
// idle_timeout_us have elapsed since the last pulse or restart (modulo 2^32).
// Every item yields exactly one result item. Pulse, restart and unused-opcode
// items, and queries that find the shaft stopped, present their result in the
// cycle after acceptance. A running query latches the operands, runs the
// period-times-pulse-count multiply that folds in four bits of the pulse
// count per cycle, then the restoring divider that retires one quotient bit
// per cycle, and loads the output register once it is free. One item is
// in flight at a time; a new item is taken while the block is idle and the
// output register is empty or being drained. Configuration writes (index 0
// pulse count per revolution, index 1 idle_timeout_us) take effect at once and
// are expected only while the block is idle. A pulse count of zero counts as
// one.
module encoder_period_tachometer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [etp_pkg::CFG_W-1:0]          i_cfg_data,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_opcode,
    input  logic [etp_pkg::TIME_W-1:0]         i_now_us,
    input  logic                               i_phase_b_level,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [etp_pkg::SPEED_W-1:0] o_speed_q8,
    output logic                               o_stopped,
    output logic                               o_direction_fwd,
    output logic [etp_pkg::TIME_W-1:0]         o_last_edge_time,
    output logic [etp_pkg::TIME_W-1:0]         o_period_us
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} t_state;

    t_state                          r_state, n_state;
    logic [etp_pkg::PPR_W-1:0]       r_ppr, n_ppr;
    logic [etp_pkg::TIME_W-1:0]      r_timeout, n_timeout;
    logic [etp_pkg::TIME_W-1:0]      r_last, n_last;
    logic [etp_pkg::TIME_W-1:0]      r_period, n_period;
    logic                            r_fwd, n_fwd;

    // output register
    logic                            r_out_valid, n_out_valid;
    logic [etp_pkg::SPEED_W-1:0]     r_speed, n_speed;
    logic                            r_stopped, n_stopped;
    logic                            r_o_fwd, n_o_fwd;
    logic [etp_pkg::TIME_W-1:0]      r_o_last, n_o_last;
    logic [etp_pkg::TIME_W-1:0]      r_o_period, n_o_period;

    logic                            accept;
    logic                            out_free;
    logic [etp_pkg::TIME_W-1:0]      elapsed;
    logic                            is_stopped;
    logic                            div_start;
    logic                            div_done;
    logic [etp_pkg::MAG_W-1:0]       div_quot;
    logic [etp_pkg::PPR_W-1:0]       ppr_eff;
    logic [etp_pkg::SPEED_W-1:0]     mag_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // idle test on wrapped timestamps
    assign elapsed    = i_now_us - r_last;
    assign is_stopped = (elapsed > r_timeout) || (r_period == '0);
    assign ppr_eff    = (r_ppr == '0) ? etp_pkg::PPR_RST : r_ppr;
    assign mag_ext    = {1'b0, div_quot};

    etp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_period (r_period),
        .i_ppr    (ppr_eff),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_ppr       = r_ppr;
        n_timeout   = r_timeout;
        n_last      = r_last;
        n_period    = r_period;
        n_fwd       = r_fwd;
        n_out_valid = r_out_valid;
        n_speed     = r_speed;
        n_stopped   = r_stopped;
        n_o_fwd     = r_o_fwd;
        n_o_last    = r_o_last;
        n_o_period  = r_o_period;
        div_start   = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etp_pkg::CFG_PPR:  n_ppr     = i_cfg_data[etp_pkg::PPR_W-1:0];
                etp_pkg::CFG_IDLE: n_timeout = i_cfg_data[etp_pkg::TIME_W-1:0];
                default: ;
            endcase
        end

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_speed   = '0;
                    n_stopped = 1'b0;
                    n_o_fwd   = r_fwd;
                    n_o_last  = r_last;
                    n_o_period = r_period;
                    unique case (etp_pkg::t_opcode'(i_opcode))
                        etp_pkg::OP_PULSE: begin
                            n_period    = i_now_us - r_last;
                            n_last      = i_now_us;
                            n_fwd       = i_phase_b_level;
                            n_o_period  = i_now_us - r_last;
                            n_o_last    = i_now_us;
                            n_o_fwd     = i_phase_b_level;
                            n_out_valid = 1'b1;
                        end
                        etp_pkg::OP_RESTART: begin
                            n_period    = '0;
                            n_last      = i_now_us;
                            n_fwd       = 1'b1;
                            n_o_period  = '0;
                            n_o_last    = i_now_us;
                            n_o_fwd     = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        etp_pkg::OP_QUERY: begin
                            if (is_stopped) begin
                                n_stopped   = 1'b1;
                                n_out_valid = 1'b1;
                            end else begin
                                // hold the result until the divider finishes
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        n_speed     = r_fwd ? mag_ext : (etp_pkg::SPEED_W'(0) - mag_ext);
                        n_stopped   = 1'b0;
                        n_o_fwd     = r_fwd;
                        n_o_last    = r_last;
                        n_o_period  = r_period;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // quotient stays in the divider until the output frees up
                if (out_free) begin
                    n_speed     = r_fwd ? mag_ext : (etp_pkg::SPEED_W'(0) - mag_ext);
                    n_stopped   = 1'b0;
                    n_o_fwd     = r_fwd;
                    n_o_last    = r_last;
                    n_o_period  = r_period;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ppr       <= etp_pkg::PPR_RST;
            r_timeout   <= etp_pkg::IDLE_TIMEOUT_RST;
            r_last      <= '0;
            r_period    <= '0;
            r_fwd       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ppr       <= n_ppr;
            r_timeout   <= n_timeout;
            r_last      <= n_last;
            r_period    <= n_period;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
        r_speed    <= n_speed;
        r_stopped  <= n_stopped;
        r_o_fwd    <= n_o_fwd;
        r_o_last   <= n_o_last;
        r_o_period <= n_o_period;
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_q8       = signed'(r_speed);
    assign o_stopped        = r_stopped;
    assign o_direction_fwd  = r_o_fwd;
    assign o_last_edge_time = r_o_last;
    assign o_period_us      = r_o_period;

    // a stopped result carries no speed
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stopped |-> r_speed == '0)
        else $error("stopped result with nonzero speed");

    // the divider only finishes while a query waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider done outside a query");

    // a running query launches the divider
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_opcode == etp_pkg::OP_QUERY && !is_stopped |=> r_state == S_DIV)
        else $error("query did not start the divider");

    // sign of a nonzero speed follows the direction and its period is nonzero
    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_speed != '0 |->
            (r_speed[etp_pkg::SPEED_W-1] == !r_o_fwd) && (r_o_period != '0))
        else $error("speed sign or period inconsistent");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for encoder_period_tachometer: a random driver and monitor
// around a cycle-free predictor. Depends on etp_pkg and the tachometer RTL.
module tb_top;
    import etp_pkg::*;

    // opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // 60e6 us per minute times 2^8 fraction bits
    localparam logic [63:0] RPM_Q8_NUM = 64'd15360000000;
    localparam logic [63:0] MAG_LIMIT  = (64'd1 << MAG_W) - 64'd1;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 152;
    localparam int REPORT_CAP = 10;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_us;
        logic              b_level;
    } tach_event_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_q8;
        logic                      stopped;
        logic                      dir_fwd;
        logic [TIME_W-1:0]         last_edge;
        logic [TIME_W-1:0]         period;
    } tach_reading_t;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_opcode = '0;
    logic [TIME_W-1:0] i_now_us = '0;
    logic i_phase_b_level = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [SPEED_W-1:0] o_speed_q8;
    logic o_stopped;
    logic o_direction_fwd;
    logic [TIME_W-1:0] o_last_edge_time;
    logic [TIME_W-1:0] o_period_us;

    encoder_period_tachometer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_now_us         (i_now_us),
        .i_phase_b_level  (i_phase_b_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_q8       (o_speed_q8),
        .o_stopped        (o_stopped),
        .o_direction_fwd  (o_direction_fwd),
        .o_last_edge_time (o_last_edge_time),
        .o_period_us      (o_period_us)
    );

    // Predictor state and its copy of the registers
    logic [TIME_W-1:0] edge_stamp_q;
    logic [TIME_W-1:0] period_q;
    logic              fwd_q;
    logic [PPR_W-1:0]  ppr_cfg;
    logic [TIME_W-1:0] idle_cfg;

    tach_event_t   pending_events[$];
    tach_reading_t expected_readings[$];
    int unsigned   fail_count = 0;

    // Handshake history seen at the last rising edge
    logic ready_seen   = 1'b0;
    logic result_taken = 1'b0;
    logic [3:0] send_gap = '0;
    logic [3:0] stall_left = '0;
    logic in_burst  = 1'b0;
    logic out_burst = 1'b0;

    // Stimulus-side view of time, used only to shape the sequences
    logic [TIME_W-1:0] gen_now;
    logic [TIME_W-1:0] gen_last;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one item to the predictor and return the reading it should produce.
    function automatic tach_reading_t tach_step(input tach_event_t ev);
        tach_reading_t r;
        logic [TIME_W-1:0] elapsed;
        logic [63:0] ppr_eff;
        logic [63:0] mag;
        r = '0;
        case (ev.op)
            OP_PULSE: begin
                period_q     = ev.now_us - edge_stamp_q;
                edge_stamp_q = ev.now_us;
                fwd_q        = ev.b_level;
            end
            OP_RESTART: begin
                edge_stamp_q = ev.now_us;
                period_q     = '0;
                fwd_q        = 1'b1;
            end
            OP_QUERY: begin
                elapsed = ev.now_us - edge_stamp_q;
                if (elapsed > idle_cfg || period_q == '0) begin
                    r.stopped = 1'b1;
                end else begin
                    // a zero pulse count behaves as one
                    ppr_eff = (ppr_cfg == '0) ? 64'd1 : 64'(ppr_cfg);
                    mag = RPM_Q8_NUM / (64'(period_q) * ppr_eff);
                    if (mag > MAG_LIMIT) mag = MAG_LIMIT;
                    r.speed_q8 = fwd_q ? SPEED_W'(mag) : SPEED_W'(-mag);
                end
            end
            default: ;
        endcase
        r.dir_fwd   = fwd_q;
        r.last_edge = edge_stamp_q;
        r.period    = period_q;
        return r;
    endfunction

    function automatic void queue_event(input logic [1:0] op, input logic [TIME_W-1:0] now,
                                        input logic b);
        tach_event_t ev;
        ev.op      = op;
        ev.now_us  = now;
        ev.b_level = b;
        pending_events.push_back(ev);
    endfunction

    // Report a field mismatch; only the first few get printed.
    task automatic flag_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] seen);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, seen);
    endtask

    // Driver: present one item at a time, hold it until taken, then idle a while.
    always @(negedge i_clk) begin
        tach_event_t ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= '0;
        end else if (i_in_valid && !ready_seen) begin
            // hold: item not yet accepted
        end else if (send_gap != '0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 4'd1;
        end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            i_opcode        <= ev.op;
            i_now_us        <= ev.now_us;
            i_phase_b_level <= ev.b_level;
            i_in_valid      <= 1'b1;
            send_gap        <= in_burst ? 4'd0 : 4'($urandom_range(0, 15));
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result side: after each taken result, drop ready for a random stretch.
    always @(negedge i_clk) begin
        logic [3:0] n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= '0;
        end else if (result_taken) begin
            n = out_burst ? 4'd0 : 4'($urandom_range(0, 15));
            stall_left  <= n;
            i_out_ready <= (n == '0);
        end else if (stall_left != '0) begin
            stall_left  <= stall_left - 4'd1;
            i_out_ready <= (stall_left == 4'd1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted item, check every accepted result.
    always @(posedge i_clk) begin
        tach_event_t   ev;
        tach_reading_t want;
        if (!i_rst_n) begin
            ready_seen   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            ready_seen   <= o_in_ready;
            result_taken <= o_out_valid && i_out_ready;
            if (i_in_valid && o_in_ready) begin
                ev.op      = i_opcode;
                ev.now_us  = i_now_us;
                ev.b_level = i_phase_b_level;
                expected_readings.push_back(tach_step(ev));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("[%0t] result with no item outstanding", $time);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_speed_q8 !== want.speed_q8)
                        flag_field("speed_q8", want.speed_q8, o_speed_q8);
                    if (o_stopped !== want.stopped)
                        flag_field("stopped", want.stopped, o_stopped);
                    if (o_direction_fwd !== want.dir_fwd)
                        flag_field("direction_fwd", want.dir_fwd, o_direction_fwd);
                    if (o_last_edge_time !== want.last_edge)
                        flag_field("last_edge_time", want.last_edge, o_last_edge_time);
                    if (o_period_us !== want.period)
                        flag_field("period_us", want.period, o_period_us);
                end
            end
        end
    end

    // Write one register; the block is idle whenever this is called.
    task automatic program_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_PPR)
            ppr_cfg = data[PPR_W-1:0];
        else
            idle_cfg = data;
    endtask

    task automatic end_cfg_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued item is taken and every reading has come back.
    task automatic wait_drained();
        while (pending_events.size() != 0 || i_in_valid || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_interval();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return $urandom_range(1, 16);
            3, 4:    return $urandom_range(1, 20000);
            5:       return $urandom_range(20000, 2000000);
            default: return $urandom();
        endcase
    endfunction

    // Elapsed time of a query, clustered around the idle timeout boundary.
    function automatic logic [TIME_W-1:0] pick_elapsed();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return idle_cfg;
            2:       return idle_cfg + 1;
            3, 4:    return $urandom_range(0, idle_cfg);
            5:       return $urandom_range(0, 50);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_ppr();
        case ($urandom_range(0, 6))
            0:       return {16'($urandom()), 16'd0};
            1:       return 32'd1;
            2:       return 32'd65535;
            3:       return $urandom_range(1, 64);
            4:       return $urandom_range(1, 2000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_timeout();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd100000;
            3:       return $urandom_range(1, 1000);
            4:       return $urandom_range(1000, 5000000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly pulse/query sequences on a running clock, with restarts and noise.
    function automatic void queue_random_event();
        int unsigned r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            gen_now  = gen_now + pick_interval();
            gen_last = gen_now;
            queue_event(OP_PULSE, gen_now, 1'($urandom_range(0, 1)));
        end else if (r < 80) begin
            gen_now = gen_last + pick_elapsed();
            queue_event(OP_QUERY, gen_now, 1'($urandom_range(0, 1)));
        end else if (r < 88) begin
            gen_now  = gen_now + $urandom_range(0, 100);
            gen_last = gen_now;
            queue_event(OP_RESTART, gen_now, 1'($urandom_range(0, 1)));
        end else if (r < 93) begin
            queue_event(OP_UNUSED, $urandom(), 1'($urandom_range(0, 1)));
        end else begin
            op = 2'($urandom_range(0, 3));
            gen_now = $urandom();
            if (op == OP_PULSE || op == OP_RESTART) gen_last = gen_now;
            queue_event(op, gen_now, 1'($urandom_range(0, 1)));
        end
    endfunction

    // Timeout guard
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        edge_stamp_q = '0;
        period_q     = '0;
        fwd_q        = 1'b1;
        ppr_cfg      = PPR_RST;
        idle_cfg     = IDLE_TIMEOUT_RST;
        gen_now      = '0;
        gen_last     = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: stopped at start, full-scale speed both ways,
        // ignored opcode, wrap of the timestamp, idle timeout boundary.
        queue_event(OP_QUERY,   32'h0000_0000, 1'b0);
        queue_event(OP_PULSE,   32'h0000_0001, 1'b1);
        queue_event(OP_QUERY,   32'h0000_0001, 1'b0);
        queue_event(OP_PULSE,   32'h0000_0002, 1'b0);
        queue_event(OP_QUERY,   32'h0000_0002, 1'b1);
        queue_event(OP_UNUSED,  32'hFFFF_FFFF, 1'b1);
        queue_event(OP_RESTART, 32'hFFFF_FFFF, 1'b0);
        queue_event(OP_PULSE,   32'h0000_00FF, 1'b1);
        queue_event(OP_QUERY,   32'h0000_00FF + 32'd100000, 1'b0);
        queue_event(OP_QUERY,   32'h0000_00FF + 32'd100001, 1'b0);
        queue_event(OP_PULSE,   32'h0000_00FE, 1'b0);
        queue_event(OP_QUERY,   32'h0000_00FE, 1'b0);
        queue_event(OP_QUERY,   32'h0000_00FD, 1'b0);
        queue_event(OP_RESTART, 32'h8000_0000, 1'b1);
        queue_event(OP_QUERY,   32'h8000_0000, 1'b1);
        wait_drained();

        // Largest pulse count, zero timeout: only a same-instant query runs.
        program_reg(CFG_PPR, 32'd65535);
        program_reg(CFG_IDLE, 32'd0);
        end_cfg_writes();
        queue_event(OP_PULSE, 32'h8000_0005, 1'b1);
        queue_event(OP_QUERY, 32'h8000_0005, 1'b0);
        queue_event(OP_QUERY, 32'h8000_0006, 1'b0);
        queue_event(OP_PULSE, 32'h8000_0005, 1'b0);
        queue_event(OP_QUERY, 32'h8000_0005, 1'b1);
        wait_drained();

        // Zero pulse count (acts as one), timeout at its maximum.
        program_reg(CFG_PPR, 32'hFFFF_0000);
        program_reg(CFG_IDLE, 32'hFFFF_FFFF);
        end_cfg_writes();
        queue_event(OP_PULSE,  32'h8000_0105, 1'b1);
        queue_event(OP_QUERY,  32'h8000_0104, 1'b0);
        queue_event(OP_UNUSED, 32'h0000_0000, 1'b0);
        wait_drained();

        gen_now  = edge_stamp_q;
        gen_last = edge_stamp_q;
        for (int p = 0; p < PHASES; p++) begin
            program_reg(CFG_PPR, pick_ppr());
            program_reg(CFG_IDLE, pick_timeout());
            end_cfg_writes();
            // some phases run back to back on one side or both
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_LEN; k++)
                queue_random_event();
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/etp_pkg.sv
hdl/etp_div.sv
hdl/encoder_period_tachometer.sv
dv/tb_top.sv
